// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define JDSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JDSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// jdsr_pkg
// Widths, constants, types and helper functions shared by the joystick
// deadband stepper rate block.
// ----------------------------------------------------------------------------
package jdsr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 21;
  localparam int AVG_W      = 16;
  localparam int CENTER_W   = 16;
  localparam int HALF_W     = 10;
  localparam int RELOAD_W   = 8;
  localparam int QUOT_W     = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CALC_W     = 16;

  localparam logic [CENTER_W-1:0] CENTER_RST = 16'd32768;
  localparam logic [HALF_W-1:0]   HALF_RST   = 10'd50;

  // avg / 100 as multiply by reciprocal: exact for all 16-bit averages
  localparam int                 DIV100_SHIFT = 23;
  localparam int                 DIV100_MUL_W = 17;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 17'd83887;

  localparam logic [RELOAD_W-1:0]      RELOAD_MAX   = 8'd248;
  localparam logic signed [CALC_W-1:0] RELOAD_MAX_S = 16'sd248;
  localparam logic signed [CALC_W-1:0] RIGHT_OFFSET = 16'sd35;
  localparam logic signed [CALC_W-1:0] LEFT_OFFSET  = 16'sd235;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 1'b0,
    CFG_HALF   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [AVG_W-1:0] lo;
    logic [AVG_W-1:0] hi;
  } band_t;

  typedef struct packed {
    logic                run;
    logic                dir_right;
    logic [RELOAD_W-1:0] reload;
    logic [AVG_W-1:0]    avg;
  } result_t;

  // band edges around the centre, saturating at both ends
  function automatic band_t band_edges(input logic [CENTER_W-1:0] center,
                                       input logic [HALF_W-1:0]   half);
    band_t             b;
    logic [CENTER_W:0] hi_sum;
    hi_sum = {1'b0, center} + (CENTER_W + 1)'(half);
    b.lo   = (center > CENTER_W'(half)) ? center - CENTER_W'(half) : '0;
    b.hi   = hi_sum[CENTER_W] ? '1 : hi_sum[CENTER_W-1:0];
    return b;
  endfunction

  // out-of-range reload values go to the maximum
  function automatic logic [RELOAD_W-1:0] clamp_reload(input logic signed [CALC_W-1:0] v);
    if (v < 0 || v > RELOAD_MAX_S) begin
      return RELOAD_MAX;
    end
    return v[RELOAD_W-1:0];
  endfunction

endpackage

// ===== hdl/joystick_deadband_stepper_rate_top.sv =====
// Joystick deadband to stepper rate. Takes one sample word per cycle and
// sums BLOCK_LEN of them. The word that closes a block is registered at its
// accepting edge, and its result is presented at the end of the path. The path
// runs through the block register, the average multiply, the divide-by-100
// multiply and the result register, so results follow at most one per cycle.
// Words that do not close a block are always taken. A closing word waits
// only when the block register, both multiply stages and the result register
// are all full and the result word is not being taken.
// Write center_value (index 0) and deadband_half_width (index 1) only while
// no block result is outstanding.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// joystick_deadband_stepper_rate_top
// Block averaging, deadband with start-up lock, and stepper reload output.
// ----------------------------------------------------------------------------
module joystick_deadband_stepper_rate_top #(
  parameter int BLOCK_LEN = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [jdsr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [jdsr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [jdsr_pkg::SAMPLE_W-1:0]    sample_count_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             motor_run_o,
  output logic                             direction_right_o,
  output logic [jdsr_pkg::RELOAD_W-1:0]    rate_reload_o,
  output logic [jdsr_pkg::AVG_W-1:0]       average_value_o
);
  import jdsr_pkg::*;

  logic [CENTER_W-1:0] center_q;
  logic [HALF_W-1:0]   half_q;
  band_t               band;
  logic                sum_valid, sum_ready;
  logic [SUM_W-1:0]    block_sum;
  logic                quot_valid, quot_ready;
  logic [AVG_W-1:0]    avg;
  logic [QUOT_W-1:0]   quot;
  result_t             result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CENTER_RST;
      half_q   <= HALF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER: center_q <= cfg_wdata_i[CENTER_W-1:0];
        CFG_HALF:   half_q   <= cfg_wdata_i[HALF_W-1:0];
      endcase
    end
  end

  assign band = band_edges(center_q, half_q);

  jdsr_accum #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_count_i (sample_count_i),
    .sum_valid_o    (sum_valid),
    .sum_ready_i    (sum_ready),
    .block_sum_o    (block_sum)
  );

  jdsr_scale #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sum_valid_i  (sum_valid),
    .sum_ready_o  (sum_ready),
    .block_sum_i  (block_sum),
    .quot_valid_o (quot_valid),
    .quot_ready_i (quot_ready),
    .avg_o        (avg),
    .quot_o       (quot)
  );

  jdsr_decide u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quot_valid_i (quot_valid),
    .quot_ready_o (quot_ready),
    .avg_i        (avg),
    .quot_i       (quot),
    .band_i       (band),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign motor_run_o       = result.run;
  assign direction_right_o = result.dir_right;
  assign rate_reload_o     = result.reload;
  assign average_value_o   = result.avg;

  `JDSR_ASSERT_IMPL(a_stop_zero_reload, out_valid_o && !motor_run_o, rate_reload_o == '0, "stopped word carries a reload")
  `JDSR_ASSERT_IMPL(a_run_reload_range, out_valid_o && motor_run_o, rate_reload_o != '0 && rate_reload_o <= RELOAD_MAX, "running reload out of range")
  `JDSR_ASSERT_IMPL(a_run_right_side, out_valid_o && motor_run_o && direction_right_o, average_value_o > band.hi, "right run without average above band")
  `JDSR_ASSERT_IMPL(a_run_left_side, out_valid_o && motor_run_o && !direction_right_o, average_value_o < band.lo, "left run without average below band")
  `JDSR_ASSERT_NEXT(a_out_fill, quot_valid && !out_valid_o, out_valid_o, "empty result register did not take waiting word")

endmodule

// ===== hdl/jdsr_accum.sv =====
// ----------------------------------------------------------------------------
// jdsr_accum
// Sums incoming samples in blocks and hands each finished block sum on
// through a one-word holding register.
// ----------------------------------------------------------------------------
module jdsr_accum #(
  parameter int BLOCK_LEN = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [jdsr_pkg::SAMPLE_W-1:0] sample_count_i,
  output logic                         sum_valid_o,
  input  logic                         sum_ready_i,
  output logic [jdsr_pkg::SUM_W-1:0]   block_sum_o
);
  import jdsr_pkg::*;

  localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_LEN - 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_next;
  logic             vld_q, vld_d;
  logic             last, slot_free, take;

  assign sum_next  = acc_q + SUM_W'(sample_count_i);
  assign last      = (cnt_q == LAST_CNT);
  assign slot_free = !vld_q || sum_ready_i;
  // only the word that closes a block needs room downstream
  assign in_ready_o = !last || slot_free;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    acc_d = acc_q;
    vld_d = vld_q;
    if (take) begin
      if (last) begin
        cnt_d = '0;
        acc_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        acc_d = sum_next;
      end
    end
    if (slot_free) begin
      vld_d = take && last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last) begin
      sum_q <= sum_next;
    end
  end

  assign sum_valid_o = vld_q;
  assign block_sum_o = sum_q;

endmodule

// ===== hdl/jdsr_scale.sv =====
// ----------------------------------------------------------------------------
// jdsr_scale
// Two registered reciprocal multiplies: block sum to average, then
// average to average / 100.
// ----------------------------------------------------------------------------
module jdsr_scale #(
  parameter int BLOCK_LEN = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sum_valid_i,
  output logic                         sum_ready_o,
  input  logic [jdsr_pkg::SUM_W-1:0]   block_sum_i,
  output logic                         quot_valid_o,
  input  logic                         quot_ready_i,
  output logic [jdsr_pkg::AVG_W-1:0]   avg_o,
  output logic [jdsr_pkg::QUOT_W-1:0]  quot_o
);
  import jdsr_pkg::*;

  // exact floor division of any SUM_W-bit value by BLOCK_LEN
  localparam int AVG_SHIFT = SUM_W + $clog2(BLOCK_LEN);
  localparam int AVG_MUL_W = SUM_W + 1;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL =
    AVG_MUL_W'(((longint'(1) << AVG_SHIFT) + longint'(BLOCK_LEN) - 1) / longint'(BLOCK_LEN));
  localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
  localparam int QUOT_PROD_W = AVG_W + DIV100_MUL_W;

  logic [AVG_PROD_W-1:0]  avg_prod;
  logic [QUOT_PROD_W-1:0] quot_prod;
  logic [AVG_W-1:0]       avg_q;
  logic [AVG_W-1:0]       avg3_q;
  logic [QUOT_W-1:0]      quot_q;
  logic                   v2_q, v3_q;
  logic                   free2, free3;

  assign free3       = !v3_q || quot_ready_i;
  assign free2       = !v2_q || free3;
  assign sum_ready_o = free2;

  assign avg_prod  = AVG_PROD_W'(block_sum_i) * AVG_PROD_W'(AVG_MUL);
  assign quot_prod = QUOT_PROD_W'(avg_q) * QUOT_PROD_W'(DIV100_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (free2) begin
        v2_q <= sum_valid_i;
      end
      if (free3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free2 && sum_valid_i) begin
      avg_q <= avg_prod[AVG_SHIFT +: AVG_W];
    end
    if (free3 && v2_q) begin
      avg3_q <= avg_q;
      quot_q <= quot_prod[DIV100_SHIFT +: QUOT_W];
    end
  end

  assign quot_valid_o = v3_q;
  assign avg_o        = avg3_q;
  assign quot_o       = quot_q;

endmodule

// ===== hdl/jdsr_decide.sv =====
// ----------------------------------------------------------------------------
// jdsr_decide
// Deadband test, start-up lock, direction and reload selection, and the
// result register.
// ----------------------------------------------------------------------------
module jdsr_decide (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         quot_valid_i,
  output logic                         quot_ready_o,
  input  logic [jdsr_pkg::AVG_W-1:0]   avg_i,
  input  logic [jdsr_pkg::QUOT_W-1:0]  quot_i,
  input  jdsr_pkg::band_t              band_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output jdsr_pkg::result_t            result_o
);
  import jdsr_pkg::*;

  logic                     lock_q, lock_d, lock_n;
  logic                     dir_q, dir_d, dir_n;
  logic                     ov_q;
  result_t                  res_q, res_d;
  logic                     free, take;
  logic                     run;
  logic [RELOAD_W-1:0]      reload;
  logic signed [CALC_W-1:0] q8, q4, right_val, left_val;

  assign free         = !ov_q || out_ready_i;
  assign quot_ready_o = free;
  assign take         = quot_valid_i && free;

  assign q8        = $signed({3'b000, quot_i, 3'b000});
  assign q4        = $signed({4'b0000, quot_i, 2'b00});
  assign right_val = q8 - RIGHT_OFFSET;
  assign left_val  = LEFT_OFFSET - q8 - q4;

  always_comb begin
    // unlock needs the average strictly inside the band
    lock_n = lock_q && !(avg_i > band_i.lo && avg_i < band_i.hi);
    dir_n  = dir_q;
    run    = 1'b0;
    reload = '0;
    if (!lock_n) begin
      priority if (avg_i < band_i.lo) begin
        reload = clamp_reload(left_val);
        dir_n  = 1'b0;
        run    = 1'b1;
      end else if (avg_i > band_i.hi) begin
        reload = clamp_reload(right_val);
        dir_n  = 1'b1;
        run    = 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    lock_d = take ? lock_n : lock_q;
    dir_d  = take ? dir_n : dir_q;
    res_d.run       = run;
    res_d.dir_right = dir_n;
    res_d.reload    = reload;
    res_d.avg       = avg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= 1'b1;
      dir_q  <= 1'b1;
      ov_q   <= 1'b0;
    end else begin
      lock_q <= lock_d;
      dir_q  <= dir_d;
      if (free) begin
        ov_q <= quot_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = ov_q;
  assign result_o    = res_q;

endmodule
